FILE: sv/skh_pkg.sv
// skh_pkg: types, constants and per-byte step functions for the selectable key hash
// no dependencies; used by selectable_key_hash and its testbench
`default_nettype none

package skh_pkg;

  localparam int NUM_BYTES  = 8;
  localparam int FNV5_BYTES = 5;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOUT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    MODE_FNV8 = 2'd0,
    MODE_FNV5 = 2'd1,
    MODE_CRC  = 2'd2,
    MODE_NAME = 2'd3
  } hash_mode_t;

  typedef struct packed {
    logic [31:0] fnv;
    logic [31:0] crc;
    logic [55:0] key_rest;
    hash_mode_t  mode;
  } stage_t;

  // one fnv-1a round, product modulo 2^32
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'h0, b};
    return x * FNV_PRIME;
  endfunction

  // one reflected crc-32 byte, folds to an xor network
  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/skh_ifs.sv
// skh_ifs: valid/ready channel interfaces for keys, hashes and the mode register
// no dependencies
`default_nettype none

interface skh_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] record_key;
  modport source (output valid, output record_key, input ready);
  modport sink (input valid, input record_key, output ready);
endinterface

interface skh_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_hash;
  modport source (output valid, output key_hash, input ready);
  modport sink (input valid, input key_hash, output ready);
endinterface

interface skh_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] hash_mode;
  modport source (output valid, output hash_mode, input ready);
  modport sink (input valid, input hash_mode, output ready);
endinterface

`default_nettype wire

FILE: sv/selectable_key_hash.sv
// selectable_key_hash: eight-stage pipelined fnv-1a / crc-32 / pass-through key hash
// depends on skh_pkg and the channel interfaces in skh_ifs.sv
`default_nettype none

// Hashes one 64-bit key (byte 0 in bits 7:0) into a 32-bit value per transfer.
// The mode register picks fnv-1a over all eight bytes, fnv-1a over bytes 0..4,
// reflected crc-32 over eight bytes, or the key's low 32 bits unchanged. The
// pipeline has eight stages, one key byte per stage: each stage does one
// constant multiply for fnv and one byte of crc, so a result is offered on the
// hash channel once its key has passed stages 0 to 7, and a new key can be
// taken every cycle unless the pipeline is full. Stalls on the result side
// back up stage by stage; bubbles are squeezed out, so the key side only
// stalls when all eight stages are full. The mode is sampled when a key enters
// and travels with it; write the register only while idle.
module selectable_key_hash
  import skh_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  skh_key_if.sink     key,
  skh_hash_if.source  hash,
  skh_cfg_if.sink     cfg
);

  // mode register
  hash_mode_t mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FNV8;
    end else if (cfg.valid) begin
      mode <= hash_mode_t'(cfg.hash_mode);
    end
  end

  // pipeline stages: stage s holds the state after key byte s
  stage_t st    [NUM_BYTES];
  logic   vld   [NUM_BYTES];
  logic   adv   [NUM_BYTES];  // stage may load this cycle
  stage_t st0_next;

  // a stage can load when empty or when its content moves on
  assign adv[NUM_BYTES-1] = !vld[NUM_BYTES-1] || hash.ready;

  // entry stage: byte 0, mode captured with the key
  always_comb begin
    st0_next.mode     = mode;
    st0_next.fnv      = (mode == MODE_NAME) ? key.record_key[31:0]
                                            : fnv_step(FNV_BASIS, key.record_key[7:0]);
    st0_next.crc      = crc_step(CRC_INIT, key.record_key[7:0]);
    st0_next.key_rest = key.record_key[63:8];
  end

  assign key.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= key.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && key.valid) begin
      st[0] <= st0_next;
    end
  end

  for (genvar s = 1; s < NUM_BYTES; s++) begin : g_stage
    stage_t st_next;
    logic   fnv_upd;

    assign adv[s-1] = !vld[s-1] || adv[s];

    // fnv runs on every byte in the 8-byte mode, on the first five in the
    // 5-byte mode, and holds the name hash untouched in pass-through mode
    always_comb begin
      fnv_upd = (st[s-1].mode == MODE_FNV8) ||
                ((st[s-1].mode == MODE_FNV5) && (s < FNV5_BYTES));
      st_next.mode     = st[s-1].mode;
      st_next.fnv      = fnv_upd ? fnv_step(st[s-1].fnv, st[s-1].key_rest[7:0])
                                 : st[s-1].fnv;
      st_next.crc      = crc_step(st[s-1].crc, st[s-1].key_rest[7:0]);
      st_next.key_rest = {8'h00, st[s-1].key_rest[55:8]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv[s]) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s] && vld[s-1]) begin
        st[s] <= st_next;
      end
    end
  end

  // result: last stage drives the hash channel, crc gets its final inversion
  assign hash.valid    = vld[NUM_BYTES-1];
  assign hash.key_hash = (st[NUM_BYTES-1].mode == MODE_CRC)
                         ? (st[NUM_BYTES-1].crc ^ CRC_XOUT)
                         : st[NUM_BYTES-1].fnv;

  // pass-through keys carry the name hash from the first stage on
  a_name_entry: assert property (@(posedge clk) disable iff (rst)
    key.valid && key.ready && (mode == MODE_NAME)
    |=> st[0].fnv == $past(key.record_key[31:0]))
    else $error("name hash not captured at entry");

  // keys are refused only when the whole pipeline is full and the result stalls
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !key.ready |-> (hash.valid && !hash.ready))
    else $error("key side stalled with room in the pipeline");

  // every key byte has been consumed by the last stage
  a_drained: assert property (@(posedge clk) disable iff (rst)
    hash.valid |-> (st[NUM_BYTES-1].key_rest == 56'h0))
    else $error("key bytes left over at the last stage");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !hash.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

FILE: dv/tb_selectable_key_hash.sv
// tb_selectable_key_hash: self-checking testbench for the selectable key hash
// depends on skh_pkg, the channel interfaces in skh_ifs.sv and selectable_key_hash
`timescale 1ns / 1ps

module tb_selectable_key_hash;
  import skh_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off, well past pipeline depth
  localparam int DRAIN_CYCLES  = 12;    // settle margin, longer than the pipeline depth
  localparam int PHASE_ITEMS   = 185;
  localparam int NUM_PHASES    = 8;

  // expected hash store plus the mode-aware hash predictor
  class hash_scoreboard;
    hash_mode_t  mode;
    logic [31:0] expected_q[$];
    int          errors;

    function new();
      mode   = MODE_FNV8;
      errors = 0;
    endfunction

    // fnv-1a 32 over the first nbytes key bytes, little-endian byte order
    static function logic [31:0] fnv1a(logic [63:0] k, int nbytes);
      logic [31:0] h;
      h = FNV_BASIS;
      for (int i = 0; i < nbytes; i++) begin
        h = h ^ {24'h0, k[i*8 +: 8]};
        h = h * FNV_PRIME;
      end
      return h;
    endfunction

    // reflected crc-32, bit serial, lsb of byte 0 first
    static function logic [31:0] crc32(logic [63:0] k);
      logic [31:0] c;
      logic        fb;
      c = CRC_INIT;
      for (int b = 0; b < 64; b++) begin
        fb = c[0] ^ k[b];
        c  = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c ^ CRC_XOUT;
    endfunction

    static function logic [31:0] key_digest(logic [63:0] k, hash_mode_t m);
      case (m)
        MODE_FNV8: return fnv1a(k, NUM_BYTES);
        MODE_FNV5: return fnv1a(k, FNV5_BYTES);
        MODE_CRC:  return crc32(k);
        default:   return k[31:0];
      endcase
    endfunction

    function void set_mode(hash_mode_t m);
      mode = m;
    endfunction

    function void note_key(logic [63:0] k);
      expected_q.push_back(key_digest(k, mode));
    endfunction

    function void check_hash(logic [31:0] got);
      logic [31:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: hash %h arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $display("%0t: key_hash mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  skh_key_if  key_ch();
  skh_hash_if hash_ch();
  skh_cfg_if  cfg_ch();

  selectable_key_hash u_dut (
    .clk  (clk),
    .rst  (rst),
    .key  (key_ch),
    .hash (hash_ch),
    .cfg  (cfg_ch)
  );

  hash_scoreboard sb;

  int send_idle_pct;       // chance per cycle that the key side sits idle
  int recv_stall_pct;      // chance per cycle that the hash side is not ready
  int hold_ticket;         // bumped to request one long receiver hold-off
  int cycle_count;

  // edge keys: zero, all ones, byte-index pattern, top and bottom bits,
  // high bytes only (invisible to five-byte fnv), low name hash only
  logic [63:0] edge_keys [6] = '{
    64'h0000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h0706_0504_0302_0100,
    64'h8000_0000_0000_0001,
    64'hFFFF_FF00_0000_0000,
    64'h0000_0000_FFFF_FFFF
  };

  // per-phase mode; idling pattern follows phase index mod 4
  hash_mode_t phase_mode [NUM_PHASES] = '{
    MODE_NAME, MODE_FNV8, MODE_FNV5, MODE_CRC,
    MODE_CRC,  MODE_NAME, MODE_FNV8, MODE_FNV5
  };

  always #6 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("selectable_key_hash verification failed");
      $finish;
    end
  end

  // hash side: check each transfer, then pick next cycle's ready
  always @(posedge clk) begin
    int hold_seen;
    int hold_left;
    if (rst) begin
      hash_ch.ready <= 1'b0;
    end else begin
      if (hash_ch.valid && hash_ch.ready) sb.check_hash(hash_ch.key_hash);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // long hold-off so the pipeline fills and backs up the key side
        hold_left--;
        hash_ch.ready <= 1'b0;
      end else begin
        hash_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // mix of dense random, single-bit, inverted single-bit and byte-pattern keys
  function automatic logic [63:0] random_key();
    logic [63:0] k;
    case ($urandom_range(5))
      3: k = 64'd1 << $urandom_range(63);
      4: k = ~(64'd1 << $urandom_range(63));
      5: begin
        for (int i = 0; i < 8; i++) begin
          case ($urandom_range(2))
            0:       k[i*8 +: 8] = 8'h00;
            1:       k[i*8 +: 8] = 8'hFF;
            default: k[i*8 +: 8] = 8'($urandom);
          endcase
        end
      end
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  // one key transfer, with random idle cycles ahead of it
  task automatic send_key(input logic [63:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      key_ch.valid      <= 1'b0;
      key_ch.record_key <= {$urandom, $urandom};   // noise while not valid
      @(posedge clk);
    end
    key_ch.valid      <= 1'b1;
    key_ch.record_key <= k;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    sb.note_key(k);
  endtask

  // mode register write; only called with the pipeline empty
  task automatic write_mode(input hash_mode_t m);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.hash_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_mode(m);
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_edge_keys();
    foreach (edge_keys[i]) send_key(edge_keys[i]);
  endtask

  initial begin
    sb                = new();
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_ticket       = 0;
    cycle_count       = 0;
    key_ch.valid      <= 1'b0;
    key_ch.record_key <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.hash_mode  <= MODE_FNV8;
    rst               <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edge keys under the reset mode, then under every other mode
    send_edge_keys();
    key_ch.valid <= 1'b0;
    wait_drain();
    write_mode(MODE_FNV5);
    send_edge_keys();
    key_ch.valid <= 1'b0;
    wait_drain();
    write_mode(MODE_CRC);
    send_edge_keys();
    key_ch.valid <= 1'b0;
    wait_drain();
    write_mode(MODE_NAME);
    send_edge_keys();
    key_ch.valid <= 1'b0;

    // random phases: mode change between phases, idling pattern per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      write_mode(phase_mode[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 88; end
        default: begin send_idle_pct = 24; recv_stall_pct <= 24; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // back-pressure: receiver holds off while keys keep coming
        if (p == 0 && i == 20) hold_ticket <= hold_ticket + 1;
        // sender pause until everything in flight has come out
        if (p == 4 && i == 90) begin
          key_ch.valid <= 1'b0;
          @(posedge clk);
          wait_drain();
        end
        send_key(random_key());
      end
      key_ch.valid <= 1'b0;
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("selectable_key_hash verification clean");
    end else begin
      $display("selectable_key_hash verification failed");
    end
    $finish;
  end

endmodule
